// File: rtl/cfm_pkg.sv
package cfm_pkg;

   // field widths
   localparam int KIND_W     = 2;
   localparam int CAPTURE_W  = 16;
   localparam int CLOCK_HZ_W = 26;
   localparam int PERIOD_W   = 32;
   localparam int OVF_W      = 16;

   // free-running timer width; one overflow adds 2^TIMER_BITS ticks
   localparam int TIMER_BITS = 16;

   // serial divider: one quotient bit per cycle over the dividend width
   localparam int DIV_STEPS  = CLOCK_HZ_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   localparam logic [CLOCK_HZ_W-1:0] CLOCK_HZ_RESET = CLOCK_HZ_W'(16000000);
   localparam logic [OVF_W-1:0]      OVF_MAX        = '1;

   // event codes
   localparam logic [KIND_W-1:0] KIND_OVERFLOW = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RISE     = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FALL     = 2'd2;

   // measurement phase
   typedef enum logic [1:0] {
      PH_ARMED,
      PH_COUNT,
      PH_FELL
   } phase_type;

   // divider sequencer
   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_DONE
   } div_state_type;

   // command from the event tracker to the divider
   typedef struct packed {
      logic [PERIOD_W-1:0]   period;
      logic [CLOCK_HZ_W-1:0] dividend;
   } div_cmd_type;

   // one result word
   typedef struct packed {
      logic [CLOCK_HZ_W-1:0] frequency_hz;
      logic [PERIOD_W-1:0]   period_ticks;
      logic                  zero_period;
   } rsp_word_type;

endpackage

// File: rtl/cfm_if.sv
interface cfm_req_if;
   import cfm_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [KIND_W-1:0]    kind;
   logic [CAPTURE_W-1:0] capture_value;
   modport source (output valid, kind, capture_value, input ready);
   modport sink   (input valid, kind, capture_value, output ready);
endinterface

interface cfm_rsp_if;
   import cfm_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CLOCK_HZ_W-1:0] frequency_hz;
   logic [PERIOD_W-1:0]   period_ticks;
   logic                  zero_period;
   modport source (output valid, frequency_hz, period_ticks, zero_period, input ready);
   modport sink   (input valid, frequency_hz, period_ticks, zero_period, output ready);
endinterface

interface cfm_csr_if;
   import cfm_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CLOCK_HZ_W-1:0] clock_hz;
   modport source (output valid, clock_hz, input ready);
   modport sink   (input valid, clock_hz, output ready);
endinterface

// File: rtl/cfm_ctrl.sv
module cfm_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [cfm_pkg::KIND_W-1:0]    req_kind,
   input  logic [cfm_pkg::CAPTURE_W-1:0] req_capture_value,
   input  logic [cfm_pkg::CLOCK_HZ_W-1:0] clock_hz,
   output logic                          cmd_valid,
   output cfm_pkg::div_cmd_type          cmd,
   input  logic                          cmd_ready
);
   import cfm_pkg::*;

   phase_type              phase_ff, phase_in;
   logic [CAPTURE_W-1:0]   start_ff, start_in;
   logic [OVF_W-1:0]       ovf_ff, ovf_in;
   logic                   accept;
   logic [PERIOD_W-1:0]    ext_ticks;

   // words are taken only while the divider can take a command
   assign req_ready = cmd_ready;
   assign accept    = req_valid && req_ready;

   // closing capture extended by the overflows, less the opening capture
   assign ext_ticks = PERIOD_W'(req_capture_value) + (PERIOD_W'(ovf_ff) << TIMER_BITS);
   assign cmd.period   = ext_ticks - PERIOD_W'(start_ff);
   assign cmd.dividend = clock_hz;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_ARMED;
         start_ff <= '0;
         ovf_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         start_ff <= start_in;
         ovf_ff   <= ovf_in;
      end
   end

   // phase tracking; code 3 falls through untouched
   always_comb begin
      phase_in  = phase_ff;
      start_in  = start_ff;
      ovf_in    = ovf_ff;
      cmd_valid = 1'b0;
      if (accept) begin
         case (phase_ff)
            PH_ARMED: begin
               if (req_kind == KIND_RISE) begin
                  start_in = req_capture_value;
                  ovf_in   = '0;
                  phase_in = PH_COUNT;
               end
            end
            PH_COUNT: begin
               if (req_kind == KIND_OVERFLOW && ovf_ff != OVF_MAX) begin
                  ovf_in = ovf_ff + 1'b1;
               end else if (req_kind == KIND_FALL) begin
                  phase_in = PH_FELL;
               end
            end
            PH_FELL: begin
               if (req_kind == KIND_OVERFLOW && ovf_ff != OVF_MAX) begin
                  ovf_in = ovf_ff + 1'b1;
               end else if (req_kind == KIND_RISE) begin
                  cmd_valid = 1'b1;
                  start_in  = '0;
                  ovf_in    = '0;
                  phase_in  = PH_ARMED;
               end
            end
            default: begin
               phase_in = PH_ARMED;
            end
         endcase
      end
   end

endmodule

// File: rtl/cfm_div.sv
module cfm_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   input  cfm_pkg::div_cmd_type  cmd,
   output logic                  cmd_ready,
   output logic                  out_valid,
   output cfm_pkg::rsp_word_type out_word,
   input  logic                  out_ready
);
   import cfm_pkg::*;

   div_state_type           state_ff, state_in;
   logic [DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [CLOCK_HZ_W-1:0]   num_ff, num_in;
   logic [CLOCK_HZ_W-1:0]   rem_ff, rem_in;
   logic [PERIOD_W-1:0]     den_ff, den_in;
   logic [CLOCK_HZ_W:0]     trial;
   logic [PERIOD_W-1:0]     diff;
   logic                    fits;

   // restoring step: bring in the next dividend bit, subtract if it fits
   assign trial = {rem_ff, num_ff[CLOCK_HZ_W-1]};
   assign fits  = PERIOD_W'(trial) >= den_ff;
   assign diff  = PERIOD_W'(trial) - den_ff;

   assign cmd_ready = (state_ff == DIV_IDLE);
   assign out_valid = (state_ff == DIV_DONE);

   // quotient has replaced the dividend in num_ff
   assign out_word.frequency_hz = (den_ff == '0) ? '0 : num_ff;
   assign out_word.period_ticks = den_ff;
   assign out_word.zero_period  = (den_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      case (state_ff)
         DIV_IDLE: begin
            if (cmd_valid) begin
               num_in   = cmd.dividend;
               den_in   = cmd.period;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = DIV_RUN;
            end
         end
         DIV_RUN: begin
            num_in = {num_ff[CLOCK_HZ_W-2:0], fits};
            rem_in = fits ? diff[CLOCK_HZ_W-1:0] : trial[CLOCK_HZ_W-1:0];
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = DIV_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         DIV_DONE: begin
            if (out_ready) begin
               state_in = DIV_IDLE;
            end
         end
         default: begin
            state_in = DIV_IDLE;
         end
      endcase
   end

   // a command only lands on an idle divider
   a_cmd_when_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_valid |-> state_ff == DIV_IDLE)
      else $error("divider command while busy");

   // step count stays within the dividend width
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == DIV_RUN |-> cnt_ff <= DIV_CNT_W'(DIV_STEPS - 1))
      else $error("divider step count out of range");

   // a zero period never reports a frequency
   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      (out_valid && out_word.zero_period) |-> out_word.frequency_hz == '0)
      else $error("zero period with nonzero frequency");

   // a run started from idle reaches the done state after its last step
   a_run_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == DIV_IDLE && cmd_valid) |=> ##(DIV_STEPS) state_ff == DIV_DONE)
      else $error("divider run length wrong");

endmodule

// File: rtl/capture_frequency_meter_core.sv
// channel   dir  handshake     payload
// req_if    in   valid/ready   kind, capture_value
// rsp_if    out  valid/ready   frequency_hz, period_ticks, zero_period
// csr_if    in   valid/ready   clock_hz (always ready)
//
// Overflow, falling, stray and opening rising words only update the phase tracker.
// A closing rising word starts the bit-serial divider, one quotient bit per
// cycle, then the result moves to the output register; the next word is taken
// once the divider has handed its result on to the output register.
// req_if.ready is low while the divider runs or holds a finished result.
// Reset is synchronous; clock_hz returns to 16000000 and the meter re-arms.
// A result stalled on rsp_if holds in the output register while the next
// measurement proceeds; a second finished division waits in the divider.
module capture_frequency_meter_core (
   input  logic      clock,
   input  logic      reset,
   cfm_req_if.sink   req_if,
   cfm_rsp_if.source rsp_if,
   cfm_csr_if.sink   csr_if
);
   import cfm_pkg::*;

   logic [CLOCK_HZ_W-1:0] clock_hz_ff, clock_hz_in;
   logic                  cmd_valid;
   div_cmd_type           cmd;
   logic                  cmd_ready;
   logic                  div_valid;
   rsp_word_type          div_word;
   logic                  div_ready;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_word_type          rsp_word_ff, rsp_word_in;

   // configuration register
   assign csr_if.ready = 1'b1;
   assign clock_hz_in  = csr_if.valid ? csr_if.clock_hz : clock_hz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_hz_ff <= CLOCK_HZ_RESET;
      end else begin
         clock_hz_ff <= clock_hz_in;
      end
   end

   cfm_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_if.valid),
      .req_ready         (req_if.ready),
      .req_kind          (req_if.kind),
      .req_capture_value (req_if.capture_value),
      .clock_hz          (clock_hz_ff),
      .cmd_valid         (cmd_valid),
      .cmd               (cmd),
      .cmd_ready         (cmd_ready)
   );

   cfm_div u_div (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_ready (cmd_ready),
      .out_valid (div_valid),
      .out_word  (div_word),
      .out_ready (div_ready)
   );

   // output register
   assign div_ready    = !rsp_valid_ff || rsp_if.ready;
   assign rsp_valid_in = div_valid || (rsp_valid_ff && !rsp_if.ready);
   assign rsp_word_in  = (div_valid && div_ready) ? div_word : rsp_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.frequency_hz = rsp_word_ff.frequency_hz;
   assign rsp_if.period_ticks = rsp_word_ff.period_ticks;
   assign rsp_if.zero_period  = rsp_word_ff.zero_period;

endmodule

// File: sim/cfm_meter_checker.sv
module cfm_meter_checker (
   input  logic clock,
   input  logic reset,
   cfm_req_if   req_mon,
   cfm_rsp_if   rsp_mon,
   cfm_csr_if   csr_mon,
   output int   fail_count,
   output int   words_checked,
   output int   words_awaited
);
   timeunit 1ns;
   timeprecision 1ps;
   import cfm_pkg::*;

   // shadow of the meter: clock setting, phase, start capture, overflow tally
   logic [CLOCK_HZ_W-1:0] clock_hz_q;
   phase_type             phase_q;
   logic [CAPTURE_W-1:0]  start_q;
   logic [OVF_W-1:0]      ovf_q;

   rsp_word_type awaited_results[$];
   int           fails;
   int           checked;

   // advance the shadow meter by one event; a closed period queues its result
   task automatic meter_event(input logic [KIND_W-1:0] kind,
                              input logic [CAPTURE_W-1:0] cap);
      logic [PERIOD_W-1:0] period;
      rsp_word_type        word;
      case (kind)
         KIND_OVERFLOW: begin
            // only counts while a measurement is open, and saturates
            if (phase_q != PH_ARMED && ovf_q != OVF_MAX)
               ovf_q = ovf_q + 1'b1;
         end
         KIND_FALL: begin
            // repeated or stray falling edges are dropped
            if (phase_q == PH_COUNT)
               phase_q = PH_FELL;
         end
         KIND_RISE: begin
            if (phase_q == PH_ARMED) begin
               start_q = cap;
               phase_q = PH_COUNT;
            end else if (phase_q == PH_FELL) begin
               // extended capture less start, wrapping at 32 bits
               period = PERIOD_W'(cap) + (PERIOD_W'(ovf_q) << TIMER_BITS)
                        - PERIOD_W'(start_q);
               word.period_ticks = period;
               word.zero_period  = (period == '0);
               word.frequency_hz = (period == '0) ? '0
                                 : CLOCK_HZ_W'(PERIOD_W'(clock_hz_q) / period);
               awaited_results.push_back(word);
               phase_q = PH_ARMED;
               start_q = '0;
               ovf_q   = '0;
            end
            // a rising edge before the falling edge is ignored
         end
         default: ;
      endcase
   endtask

   // sample all three channels on the clock edge
   always @(posedge clock) begin : monitor
      rsp_word_type want;
      rsp_word_type got;
      if (reset) begin
         clock_hz_q = CLOCK_HZ_RESET;
         phase_q    = PH_ARMED;
         start_q    = '0;
         ovf_q      = '0;
         awaited_results.delete();
         fails      = 0;
         checked    = 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready)
            clock_hz_q = csr_mon.clock_hz;
         if (req_mon.valid && req_mon.ready)
            meter_event(req_mon.kind, req_mon.capture_value);
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.frequency_hz = rsp_mon.frequency_hz;
            got.period_ticks = rsp_mon.period_ticks;
            got.zero_period  = rsp_mon.zero_period;
            if (awaited_results.size() == 0) begin
               fails++;
               if (fails <= 10)
                  $display("unexpected result word: freq %0d period %0d zero %0b",
                           got.frequency_hz, got.period_ticks, got.zero_period);
            end else begin
               want = awaited_results.pop_front();
               checked++;
               if (got.frequency_hz !== want.frequency_hz ||
                   got.period_ticks !== want.period_ticks ||
                   got.zero_period !== want.zero_period) begin
                  fails++;
                  if (fails <= 10) begin
                     $display("result %0d wrong: want freq %0d period %0d zero %0b",
                              checked, want.frequency_hz, want.period_ticks,
                              want.zero_period);
                     $display("   got freq %0d period %0d zero %0b",
                              got.frequency_hz, got.period_ticks, got.zero_period);
                  end
               end
            end
         end
      end
      // published after the edge so readers see a settled value
      fail_count    <= fails;
      words_checked <= checked;
      words_awaited <= awaited_results.size();
   end

endmodule

// File: sim/capture_frequency_meter_core_tb.sv
module capture_frequency_meter_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import cfm_pkg::*;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int RESET_CYCLES  = 9;
   localparam int MAX_WAIT      = 11;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int RANDOM_WORDS  = 1750;

   logic clock = 1'b0;
   logic reset;

   cfm_req_if req_if ();
   cfm_rsp_if rsp_if ();
   cfm_csr_if csr_if ();

   int fail_count;
   int words_checked;
   int words_awaited;
   int words_sent;
   int settings_used;
   int cycle_count;
   bit no_idle;

   always #2ns clock = ~clock;

   capture_frequency_meter_core u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   cfm_meter_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_if),
      .rsp_mon       (rsp_if),
      .csr_mon       (csr_if),
      .fail_count    (fail_count),
      .words_checked (words_checked),
      .words_awaited (words_awaited)
   );

   // watchdog
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("run stopped at the cycle limit with %0d results outstanding",
                  words_awaited);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic int draw_wait();
      return no_idle ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   // result side: random stall before each word
   initial begin : result_sink
      int stall;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = draw_wait();
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   // one event word; valid stays high on return so a back-to-back word follows
   task automatic send_word(input logic [KIND_W-1:0] kind,
                            input logic [CAPTURE_W-1:0] cap);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.kind          <= kind;
      req_if.capture_value <= cap;
      do @(posedge clock); while (!req_if.ready);
      words_sent++;
   endtask

   // drop valid, let every result drain, then allow for a divide in flight
   task automatic await_idle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (words_awaited != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_clock_hz(input logic [CLOCK_HZ_W-1:0] value);
      await_idle();
      csr_if.valid    <= 1'b1;
      csr_if.clock_hz <= value;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      settings_used++;
   endtask

   // open, overflows, fall, overflows, close; optional stray words in between
   task automatic measure(input logic [CAPTURE_W-1:0] start_cap,
                          input int ovf_open, input int ovf_fell,
                          input logic [CAPTURE_W-1:0] stop_cap, input bit noisy);
      send_word(KIND_RISE, start_cap);
      if (noisy && $urandom_range(0, 1) == 1)
         send_word(KIND_RISE, 16'($urandom));
      repeat (ovf_open) send_word(KIND_OVERFLOW, 16'($urandom));
      if (noisy && $urandom_range(0, 2) == 0)
         send_word(KIND_UNUSED, 16'($urandom));
      send_word(KIND_FALL, 16'($urandom));
      if (noisy && $urandom_range(0, 1) == 1)
         send_word(KIND_FALL, 16'($urandom));
      repeat (ovf_fell) send_word(KIND_OVERFLOW, 16'($urandom));
      send_word(KIND_RISE, stop_cap);
   endtask

   initial begin : stimulus
      int target;
      int next_setting;
      int next_mode;
      int ovf_open;
      int ovf_fell;
      logic [CAPTURE_W-1:0] start_cap;
      logic [CAPTURE_W-1:0] stop_cap;
      logic [CLOCK_HZ_W-1:0] new_clock;

      reset                <= 1'b1;
      req_if.valid         <= 1'b0;
      req_if.kind          <= KIND_OVERFLOW;
      req_if.capture_value <= '0;
      csr_if.valid         <= 1'b0;
      csr_if.clock_hz      <= CLOCK_HZ_RESET;
      words_sent    = 0;
      settings_used = 0;
      no_idle       = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: stray words while armed, then the edge cases of one period
      send_word(KIND_UNUSED, 16'hFFFF);
      send_word(KIND_OVERFLOW, 16'h5A5A);
      send_word(KIND_FALL, 16'h0001);
      send_word(KIND_RISE, 16'hFFFF);
      send_word(KIND_RISE, 16'h1234);
      send_word(KIND_UNUSED, 16'h0000);
      send_word(KIND_OVERFLOW, 16'h0000);
      send_word(KIND_OVERFLOW, 16'hFFFF);
      send_word(KIND_FALL, 16'hFFFF);
      send_word(KIND_FALL, 16'h0000);
      send_word(KIND_RISE, 16'h0000);
      measure(16'h00AA, 0, 0, 16'h00AA, 1'b0);   // zero period
      measure(16'hFFFF, 0, 0, 16'h0000, 1'b0);   // period wraps negative
      measure(16'h0005, 0, 0, 16'h0006, 1'b0);   // one tick

      // clock setting extremes, each with a short period
      write_clock_hz('0);
      measure(16'h0010, 0, 0, 16'h0020, 1'b0);
      write_clock_hz(CLOCK_HZ_W'(50000000));
      measure(16'h0000, 0, 0, 16'h0001, 1'b0);
      write_clock_hz('1);
      measure(16'h8000, 0, 0, 16'h8001, 1'b0);
      write_clock_hz(CLOCK_HZ_W'(1));
      measure(16'h1000, 0, 0, 16'h1001, 1'b0);
      measure(16'h1000, 0, 0, 16'h1002, 1'b0);

      // random: mostly whole measurements, some stray words
      write_clock_hz(CLOCK_HZ_RESET);
      target       = words_sent + RANDOM_WORDS;
      next_setting = words_sent + 350;
      next_mode    = words_sent + 40;
      while (words_sent < target) begin
         if (words_sent >= next_setting) begin
            case ($urandom_range(0, 5))
               0:       new_clock = CLOCK_HZ_W'(1);
               1:       new_clock = CLOCK_HZ_W'(50000000);
               2:       new_clock = '1;
               3:       new_clock = '0;
               default: new_clock = CLOCK_HZ_W'($urandom_range(1, 50000000));
            endcase
            write_clock_hz(new_clock);
            next_setting = words_sent + 350;
         end
         if (words_sent >= next_mode) begin
            no_idle   = ($urandom_range(0, 3) == 0);
            next_mode = words_sent + 40;
         end
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 4))
               send_word(KIND_W'($urandom_range(0, 3)), 16'($urandom));
         end else begin
            start_cap = 16'($urandom);
            ovf_open  = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 40)
                                                    : $urandom_range(0, 2);
            ovf_fell  = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 40)
                                                    : $urandom_range(0, 2);
            case ($urandom_range(0, 7))
               0: begin
                  // zero period
                  ovf_open = 0;
                  ovf_fell = 0;
                  stop_cap = start_cap;
               end
               1:       stop_cap = start_cap + 16'($urandom_range(1, 15));
               default: stop_cap = 16'($urandom);
            endcase
            measure(start_cap, ovf_open, ovf_fell, stop_cap,
                    $urandom_range(0, 3) == 0);
         end
      end

      await_idle();
      $display("sent %0d event words over %0d clock settings, %0d results checked",
               words_sent, settings_used, words_checked);
      if (fail_count == 0 && words_awaited == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
